/* rtl/hcbd_pkg.sv */
`timescale 1ns / 1ps

package hcbd_pkg;

   // Byte codes of the chunk framing
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   // Size limit register
   localparam int          LIMIT_W        = 25;
   localparam int          LENGTH_W       = 24;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd262144;
   localparam logic [LIMIT_W-1:0] LENGTH_CAP  = 25'd16777216;

   // Register map
   localparam logic REG_BODY_LIMIT = 1'b0;

   // Default longest size line, in hex digits
   localparam int MAX_SIZE_DIGITS_DEF = 15;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                out_valid;
      logic                body_done;
      logic                format_error;
      logic [LENGTH_W-1:0] total_length;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // ASCII hex digit to nibble; ok is low for any other byte
   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

/* rtl/hcbd_decoder.sv */
`timescale 1ns / 1ps

// Chunk framing state machine: holds the parse state and works out the
// result of one byte in the same cycle. State moves only on fire.
module hcbd_decoder #(
   parameter int MAX_SIZE_DIGITS = hcbd_pkg::MAX_SIZE_DIGITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  hcbd_pkg::req_type            req,
   input  logic [hcbd_pkg::LIMIT_W-1:0] body_limit,
   output hcbd_pkg::rsp_type            rsp
);

   localparam int CHUNK_W = 4 * MAX_SIZE_DIGITS;
   localparam int COUNT_W = $clog2(MAX_SIZE_DIGITS + 1);
   localparam int SUM_W   = ((CHUNK_W > hcbd_pkg::LENGTH_W) ? CHUNK_W : hcbd_pkg::LENGTH_W) + 1;

   typedef enum logic [2:0] {
      PH_SIZE_FIRST,
      PH_SIZE_MORE,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type                     phase_ff, phase_in, phase_cur;
   logic [CHUNK_W-1:0]            chunk_ff, chunk_in, chunk_cur;
   logic [COUNT_W-1:0]            count_ff, count_in, count_cur;
   logic [hcbd_pkg::LENGTH_W-1:0] total_ff, total_in, total_cur;
   logic                          final_ff, final_in, final_cur;

   hcbd_pkg::hex_type             hex;
   logic [hcbd_pkg::LIMIT_W-1:0]  lim;
   logic [SUM_W-1:0]              sum;

   // A start request sees a freshly cleared state
   always_comb begin
      if (req.start_req) begin
         phase_cur = PH_SIZE_FIRST;
         chunk_cur = '0;
         count_cur = '0;
         total_cur = '0;
         final_cur = 1'b0;
      end else begin
         phase_cur = phase_ff;
         chunk_cur = chunk_ff;
         count_cur = count_ff;
         total_cur = total_ff;
         final_cur = final_ff;
      end
   end

   assign hex = hcbd_pkg::hex_decode(req.in_byte);
   assign lim = (body_limit > hcbd_pkg::LENGTH_CAP) ? hcbd_pkg::LENGTH_CAP : body_limit;
   assign sum = SUM_W'(total_cur) + SUM_W'(chunk_cur);

   // Per-byte transition and result
   always_comb begin
      phase_in = phase_cur;
      chunk_in = chunk_cur;
      count_in = count_cur;
      total_in = total_cur;
      final_in = final_cur;
      rsp      = '0;
      case (phase_cur)
         PH_SIZE_FIRST: begin
            if (!hex.ok) begin
               rsp.format_error = 1'b1;
               phase_in         = PH_ERROR;
            end else begin
               chunk_in = CHUNK_W'(hex.value);
               count_in = COUNT_W'(1);
               phase_in = PH_SIZE_MORE;
            end
         end
         PH_SIZE_MORE: begin
            if (req.in_byte == hcbd_pkg::BYTE_CR) begin
               phase_in = PH_SIZE_LF;
            end else if (!hex.ok || count_cur >= COUNT_W'(MAX_SIZE_DIGITS)) begin
               rsp.format_error = 1'b1;
               phase_in         = PH_ERROR;
            end else begin
               chunk_in = (chunk_cur << 4) | CHUNK_W'(hex.value);
               count_in = count_cur + COUNT_W'(1);
            end
         end
         PH_SIZE_LF: begin
            // size line ends: also the point where the limit is enforced
            if (req.in_byte != hcbd_pkg::BYTE_LF || sum >= SUM_W'(lim)) begin
               rsp.format_error = 1'b1;
               phase_in         = PH_ERROR;
            end else begin
               count_in = '0;
               if (chunk_cur == '0) begin
                  final_in = 1'b1;
                  phase_in = PH_DATA_CR;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            rsp.out_byte  = req.in_byte;
            rsp.out_valid = 1'b1;
            total_in      = total_cur + hcbd_pkg::LENGTH_W'(1);
            chunk_in      = chunk_cur - CHUNK_W'(1);
            if (chunk_cur == CHUNK_W'(1)) begin
               phase_in = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            if (req.in_byte != hcbd_pkg::BYTE_CR) begin
               rsp.format_error = 1'b1;
               phase_in         = PH_ERROR;
            end else begin
               phase_in = PH_DATA_LF;
            end
         end
         PH_DATA_LF: begin
            if (req.in_byte != hcbd_pkg::BYTE_LF) begin
               rsp.format_error = 1'b1;
               phase_in         = PH_ERROR;
            end else if (final_cur) begin
               rsp.body_done    = 1'b1;
               rsp.total_length = total_cur;
               phase_in         = PH_DONE;
            end else begin
               phase_in = PH_SIZE_FIRST;
            end
         end
         default: begin
            // done or error: hold until a start request
         end
      endcase
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE_FIRST;
         chunk_ff <= '0;
         count_ff <= '0;
         total_ff <= '0;
         final_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         chunk_ff <= chunk_in;
         count_ff <= count_in;
         total_ff <= total_in;
         final_ff <= final_in;
      end
   end

   // Payload bytes only flow while a chunk is open
   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (chunk_ff != '0))
      else $error("data phase entered with no bytes left");

   // A zero-size line that is taken sets the last-chunk flag
   a_final_zero: assert property (@(posedge clock) disable iff (reset)
      (fire && !req.start_req && phase_ff == PH_SIZE_LF && !rsp.format_error
       && chunk_ff == '0) |=> final_ff)
      else $error("zero-size chunk did not mark the last chunk");

   // Digit count never runs past the longest size line
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SIZE_DIGITS))
      else $error("size digit count out of range");

endmodule

/* rtl/http_chunked_body_decoder.sv */
`timescale 1ns / 1ps

// HTTP/1.1 chunked body decoder. Takes one raw body byte per request and
// returns one result per request: the payload byte with out_valid, a done
// flag with the total length on the LF closing the zero-size chunk, or a
// format error; after done or error results are all zero until a request
// with start_req set. Throughput is one byte per clock while rsp_ready is
// high: the byte is held in an input register, decoded combinationally by
// the framing state machine and written into the result register, which
// drives rsp_valid. The size limit (body_limit, byte address 0, values
// above 2^24 act as 2^24) is checked on the LF of each size line and
// must only be written while no request is in flight.
module http_chunked_body_decoder #(
   parameter int MAX_SIZE_DIGITS = hcbd_pkg::MAX_SIZE_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  hcbd_pkg::req_type req_data,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hcbd_pkg::rsp_type rsp_data,

   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic                         limit_sel;
   logic [hcbd_pkg::LIMIT_W-1:0] body_limit_ff;
   logic                         in_valid_ff;
   hcbd_pkg::req_type            in_data_ff;
   logic                         out_valid_ff;
   hcbd_pkg::rsp_type            out_data_ff;
   hcbd_pkg::rsp_type            step_rsp;
   logic                         advance;

   // Register port
   assign pready    = 1'b1;
   assign limit_sel = (paddr[2] == hcbd_pkg::REG_BODY_LIMIT);
   assign prdata    = limit_sel ? {{(32 - hcbd_pkg::LIMIT_W){1'b0}}, body_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_limit_ff <= hcbd_pkg::LIMIT_RESET;
      end else if (psel && penable && pwrite && limit_sel) begin
         body_limit_ff <= pwdata[hcbd_pkg::LIMIT_W-1:0];
      end
   end

   // Pipeline control: decode moves when the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   hcbd_decoder #(
      .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .req       (in_data_ff),
      .body_limit(body_limit_ff),
      .rsp       (step_rsp)
   );

   // At most one kind of event per result
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ($countones({out_data_ff.out_valid, out_data_ff.body_done,
                                    out_data_ff.format_error}) <= 1))
      else $error("result carries more than one event");

   // Fields outside their event read as zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_data_ff.out_valid || out_data_ff.out_byte == '0)
                        && (out_data_ff.body_done || out_data_ff.total_length == '0)))
      else $error("idle result field not zero");

   // A held input request is not lost while the result slot is blocked
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("stalled request dropped or changed");

endmodule
